// ----- hw/rtl/hpdc_pkg.sv -----
package hpdc_pkg;

	localparam int MAG_W      = 32;
	localparam int SUM_W      = 40;
	localparam int DB_W       = 17;
	localparam int POS_W      = 7;
	localparam int CNT_W      = 8;
	localparam int DBSUM_W    = 24;
	localparam int LOG_INT_W  = 6;
	localparam int LOG_FRAC_W = 16;
	localparam int DB_K_W     = 19;

	// -120 dB in Q8.8
	localparam logic signed [DB_W-1:0] DB_FLOOR = -17'sd30720;
	// round(20*log10(2) * 2^16)
	localparam logic [DB_K_W-1:0] DB_K = 19'd394566;

	localparam int JOB_FIFO_DEPTH = 4;
	localparam int JOB_PTR_W      = 2;

	typedef enum logic {
		JOB_LEVEL   = 1'b0,
		JOB_COMBINE = 1'b1
	} job_kind_t;

	typedef enum logic {
		MODE_SUM     = 1'b0,
		MODE_GEOMEAN = 1'b1
	} combine_mode_t;

	typedef struct packed {
		job_kind_t           kind;
		combine_mode_t       mode;
		logic [SUM_W-1:0]    operand;
		logic [POS_W-1:0]    pos;
	} job_t;

	typedef struct packed {
		logic             start;
		logic [SUM_W-1:0] x;
	} log_req_t;

	typedef struct packed {
		logic                   done;
		logic signed [DB_W-1:0] db;
	} log_rsp_t;

endpackage

// ----- hw/rtl/hpdc_ifs.sv -----
interface hpdc_in_if import hpdc_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [MAG_W-1:0] magnitude;
	logic             last_harmonic;

	modport source(output valid, magnitude, last_harmonic, input ready);
	modport sink(input valid, magnitude, last_harmonic, output ready);
endinterface

interface hpdc_out_if import hpdc_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic signed [DB_W-1:0] level_db;
	logic                   is_combined;
	logic [POS_W-1:0]       harmonic_number;
	logic                   frame_done;

	modport source(output valid, level_db, is_combined, harmonic_number, frame_done,
		input ready);
	modport sink(input valid, level_db, is_combined, harmonic_number, frame_done,
		output ready);
endinterface

// ----- hw/rtl/hpdc_front.sv -----
module hpdc_front import hpdc_pkg::*; #(
	parameter int MAX_HARMONICS = 128
) (
	input  logic          clk,
	input  logic          arst_n,
	hpdc_in_if.sink       harmonic,
	input  combine_mode_t mode,
	output job_t          job,
	output logic          job_push,
	input  logic          fifo_full
);

	localparam logic [POS_W-1:0] LAST_POS = POS_W'(MAX_HARMONICS - 1);

	logic [POS_W-1:0] pos_q;
	logic [SUM_W-1:0] magsum_q;
	logic             pend_q;
	job_t             pend_job_q;

	logic             accept;
	logic             closing;
	logic [SUM_W-1:0] magsum_nxt;

	assign harmonic.ready = !pend_q && !fifo_full;
	assign accept         = harmonic.valid && harmonic.ready;
	assign closing        = harmonic.last_harmonic || (pos_q >= LAST_POS);
	assign magsum_nxt     = magsum_q + SUM_W'(harmonic.magnitude);
	// the combine request goes out after its closing level request, once the queue has room
	assign job_push       = accept || (pend_q && !fifo_full);

	always_comb begin
		if (pend_q) begin
			job = pend_job_q;
		end else begin
			job.kind    = JOB_LEVEL;
			job.mode    = mode;
			job.operand = SUM_W'(harmonic.magnitude);
			job.pos     = pos_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			magsum_q <= '0;
			pend_q   <= 1'b0;
		end else begin
			if (accept) begin
				if (closing) begin
					pos_q    <= '0;
					magsum_q <= '0;
					pend_q   <= 1'b1;
				end else begin
					pos_q    <= pos_q + 1'b1;
					magsum_q <= magsum_nxt;
				end
			end else if (pend_q && !fifo_full) begin
				pend_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && closing) begin
			pend_job_q.kind    <= JOB_COMBINE;
			pend_job_q.mode    <= mode;
			pend_job_q.operand <= magsum_nxt;
			pend_job_q.pos     <= pos_q;
		end
	end

	a_push_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		job_push |-> !fifo_full)
		else $error("request pushed into full queue");

	a_close_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && closing) |=> (pend_q && pos_q == '0 && magsum_q == '0))
		else $error("frame close did not restart accumulation");

endmodule

// ----- hw/rtl/hpdc_job_fifo.sv -----
module hpdc_job_fifo import hpdc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	input  logic pop,
	output job_t pop_job,
	output logic full,
	output logic empty
);

	localparam logic [JOB_PTR_W:0] DEPTH_CNT = (JOB_PTR_W + 1)'(JOB_FIFO_DEPTH);

	job_t                 mem_q [JOB_FIFO_DEPTH];
	logic [JOB_PTR_W-1:0] wr_ptr_q;
	logic [JOB_PTR_W-1:0] rd_ptr_q;
	logic [JOB_PTR_W:0]   cnt_q;

	logic do_push;
	logic do_pop;

	assign full    = (cnt_q == DEPTH_CNT);
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign pop_job = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

// ----- hw/rtl/hpdc_log_db.sv -----
module hpdc_log_db import hpdc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  log_req_t req,
	output log_rsp_t rsp
);

	localparam int PROD_W = LOG_INT_W + LOG_FRAC_W + DB_K_W;
	localparam logic [3:0] NORM_LAST = 4'd5;
	localparam logic [3:0] SQR_LAST  = 4'd15;
	// 2^23 rounding minus the 16.0 offset of the Q24.16 input, scaled by K
	localparam logic signed [PROD_W:0] DB_BIAS =
		(PROD_W + 1)'((longint'(1) << 23) - (longint'(DB_K) << 20));

	typedef enum logic [4:0] {
		LG_IDLE = 5'b00001,
		LG_NORM = 5'b00010,
		LG_SQR  = 5'b00100,
		LG_MUL  = 5'b01000,
		LG_FIN  = 5'b10000
	} lg_state_t;

	lg_state_t             st_q;
	logic [3:0]            step_q;
	logic [SUM_W-1:0]      norm_q;
	logic [LOG_INT_W-1:0]  exp_q;
	logic [MAG_W-1:0]      man_q;
	logic [LOG_FRAC_W-1:0] frac_q;
	logic [PROD_W-1:0]     prod_q;
	logic                  zero_q;

	logic [SUM_W-1:0]      norm_nxt;
	logic [LOG_INT_W-1:0]  exp_nxt;
	logic [2*MAG_W-1:0]    sq;
	logic [MAG_W:0]        sq_top;
	logic [PROD_W-1:0]     prod_nxt;
	logic signed [PROD_W:0] db_full;

	// binary-search normalization: one shift width per cycle
	always_comb begin
		norm_nxt = norm_q;
		exp_nxt  = exp_q;
		case (step_q)
			4'd0: if (norm_q[SUM_W-1 -: 32] == '0) begin
				norm_nxt = norm_q << 32;
				exp_nxt  = exp_q - 6'd32;
			end
			4'd1: if (norm_q[SUM_W-1 -: 16] == '0) begin
				norm_nxt = norm_q << 16;
				exp_nxt  = exp_q - 6'd16;
			end
			4'd2: if (norm_q[SUM_W-1 -: 8] == '0) begin
				norm_nxt = norm_q << 8;
				exp_nxt  = exp_q - 6'd8;
			end
			4'd3: if (norm_q[SUM_W-1 -: 4] == '0) begin
				norm_nxt = norm_q << 4;
				exp_nxt  = exp_q - 6'd4;
			end
			4'd4: if (norm_q[SUM_W-1 -: 2] == '0) begin
				norm_nxt = norm_q << 2;
				exp_nxt  = exp_q - 6'd2;
			end
			4'd5: if (!norm_q[SUM_W-1]) begin
				norm_nxt = norm_q << 1;
				exp_nxt  = exp_q - 6'd1;
			end
			default: begin
				norm_nxt = norm_q;
				exp_nxt  = exp_q;
			end
		endcase
	end

	assign sq       = man_q * man_q;
	assign sq_top   = sq[2*MAG_W-1:MAG_W-1];
	assign prod_nxt = {exp_q, frac_q} * DB_K;
	assign db_full  = $signed({1'b0, prod_q}) + DB_BIAS;

	assign rsp.done = (st_q == LG_FIN);
	assign rsp.db   = zero_q ? DB_FLOOR : db_full[DB_W+23:24];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= LG_IDLE;
			step_q <= '0;
		end else begin
			case (st_q)
				LG_IDLE: begin
					step_q <= '0;
					if (req.start) begin
						st_q <= (req.x == '0) ? LG_FIN : LG_NORM;
					end
				end
				LG_NORM: begin
					if (step_q == NORM_LAST) begin
						step_q <= '0;
						st_q   <= LG_SQR;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				LG_SQR: begin
					if (step_q == SQR_LAST) begin
						step_q <= '0;
						st_q   <= LG_MUL;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				LG_MUL:  st_q <= LG_FIN;
				LG_FIN:  st_q <= LG_IDLE;
				default: st_q <= LG_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			LG_IDLE: begin
				norm_q <= req.x;
				exp_q  <= LOG_INT_W'(SUM_W - 1);
				zero_q <= (req.x == '0);
				frac_q <= '0;
			end
			LG_NORM: begin
				norm_q <= norm_nxt;
				exp_q  <= exp_nxt;
				man_q  <= norm_nxt[SUM_W-1 -: MAG_W];
			end
			LG_SQR: begin
				// square in [1,4); a carry past 2 gives a one bit and a halving
				frac_q <= {frac_q[LOG_FRAC_W-2:0], sq_top[MAG_W]};
				man_q  <= sq_top[MAG_W] ? sq_top[MAG_W:1] : sq_top[MAG_W-1:0];
			end
			LG_MUL: prod_q <= prod_nxt;
			default: ;
		endcase
	end

endmodule

// ----- hw/rtl/hpdc_back.sv -----
module hpdc_back import hpdc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  job_t     job,
	input  logic     job_empty,
	output logic     job_pop,
	output log_req_t log_req,
	input  log_rsp_t log_rsp,
	hpdc_out_if.source result
);

	localparam logic [4:0] DIV_STEPS = 5'(DBSUM_W);

	typedef enum logic [3:0] {
		BK_IDLE = 4'b0001,
		BK_LOG  = 4'b0010,
		BK_DIV  = 4'b0100,
		BK_EMIT = 4'b1000
	} bk_state_t;

	bk_state_t                 st_q;
	logic signed [DBSUM_W-1:0] db_sum_q;
	logic [CNT_W-1:0]          nz_cnt_q;
	logic                      out_valid_q;

	job_kind_t                 kind_q;
	logic [POS_W-1:0]          pos_q;
	logic                      nz_q;
	logic signed [DB_W-1:0]    res_q;
	logic [DBSUM_W-1:0]        num_q;
	logic [CNT_W-1:0]          den_q;
	logic [CNT_W-1:0]          rem_q;
	logic [4:0]                div_cnt_q;
	logic                      neg_q;

	logic signed [DB_W-1:0]    level_q;
	logic                      comb_q;
	logic [POS_W-1:0]          num_out_q;

	logic                      out_free;
	logic                      take_log;
	logic [DBSUM_W-1:0]        abs_sum;
	logic [CNT_W:0]            trial;
	logic [CNT_W:0]            trial_diff;
	logic                      qbit;
	logic [DBSUM_W-1:0]        quot;
	logic [DB_W-1:0]           quot_lo;

	assign out_free  = !out_valid_q || result.ready;
	assign job_pop   = (st_q == BK_IDLE) && !job_empty;
	assign take_log  = (job.kind == JOB_LEVEL) || (job.mode == MODE_SUM);
	assign log_req.start = job_pop && take_log;
	assign log_req.x     = job.operand;

	assign abs_sum    = db_sum_q[DBSUM_W-1] ? DBSUM_W'(-db_sum_q) : DBSUM_W'(db_sum_q);
	// restoring division, one quotient bit per cycle
	assign trial      = {rem_q, num_q[DBSUM_W-1]};
	assign trial_diff = trial - {1'b0, den_q};
	assign qbit       = (trial >= {1'b0, den_q});
	assign quot       = {num_q[DBSUM_W-2:0], qbit};
	assign quot_lo    = quot[DB_W-1:0];

	assign result.valid           = out_valid_q;
	assign result.level_db        = level_q;
	assign result.is_combined     = comb_q;
	assign result.harmonic_number = num_out_q;
	assign result.frame_done      = comb_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= BK_IDLE;
			db_sum_q    <= '0;
			nz_cnt_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (st_q == BK_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			case (st_q)
				BK_IDLE: begin
					if (!job_empty) begin
						if (job.kind == JOB_COMBINE) begin
							db_sum_q <= '0;
							nz_cnt_q <= '0;
						end
						if (take_log) begin
							st_q <= BK_LOG;
						end else if (nz_cnt_q == '0) begin
							st_q <= BK_EMIT;
						end else begin
							st_q <= BK_DIV;
						end
					end
				end
				BK_LOG: begin
					if (log_rsp.done) begin
						if (kind_q == JOB_LEVEL && nz_q) begin
							db_sum_q <= db_sum_q + DBSUM_W'(log_rsp.db);
							nz_cnt_q <= nz_cnt_q + 1'b1;
						end
						st_q <= BK_EMIT;
					end
				end
				BK_DIV: begin
					if (div_cnt_q == 5'd1) begin
						st_q <= BK_EMIT;
					end
				end
				BK_EMIT: begin
					if (out_free) begin
						st_q <= BK_IDLE;
					end
				end
				default: st_q <= BK_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			BK_IDLE: begin
				kind_q    <= job.kind;
				pos_q     <= job.pos;
				nz_q      <= (job.operand != '0);
				res_q     <= '0;
				neg_q     <= db_sum_q[DBSUM_W-1];
				num_q     <= abs_sum + DBSUM_W'(nz_cnt_q >> 1);
				den_q     <= nz_cnt_q;
				rem_q     <= '0;
				div_cnt_q <= DIV_STEPS;
			end
			BK_LOG: begin
				if (log_rsp.done) begin
					res_q <= log_rsp.db;
				end
			end
			BK_DIV: begin
				rem_q     <= qbit ? trial_diff[CNT_W-1:0] : trial[CNT_W-1:0];
				num_q     <= quot;
				div_cnt_q <= div_cnt_q - 1'b1;
				if (div_cnt_q == 5'd1) begin
					res_q <= neg_q ? -$signed(quot_lo) : $signed(quot_lo);
				end
			end
			BK_EMIT: begin
				if (out_free) begin
					level_q   <= res_q;
					comb_q    <= (kind_q == JOB_COMBINE);
					num_out_q <= pos_q;
				end
			end
			default: ;
		endcase
	end

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == BK_DIV) |-> (den_q != '0))
		else $error("division started with zero count");

	a_emit_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == BK_EMIT && out_free) |=> (result.valid && st_q == BK_IDLE))
		else $error("result not loaded into output register");

endmodule

// ----- hw/rtl/harmonic_power_db_combiner_unit.sv -----
// A harmonic's level result becomes valid after its request is accepted and the log
// unit has run, with the back end idle and the output free; for a zero magnitude the
// log unit skips its steps. The combined result follows (log or 24-step divide); a zero
// sum skips the log steps, and mean mode without input goes straight to the output.
// The log unit has 6 normalize and 16 squaring steps; the 4-deep queue absorbs bursts.
// Reset clears all accumulators, the queue and the output; combine_mode resets to 0.
module harmonic_power_db_combiner_unit import hpdc_pkg::*; #(
	parameter int MAX_HARMONICS = 128
) (
	input  logic clk,
	input  logic arst_n,
	hpdc_in_if.sink    harmonic,
	hpdc_out_if.source result,
	input  logic cfg_we,
	input  logic cfg_wdata
);

	combine_mode_t combine_mode_q;

	job_t     push_job;
	job_t     pop_job;
	logic     job_push;
	logic     job_pop;
	logic     fifo_full;
	logic     fifo_empty;
	log_req_t log_req;
	log_rsp_t log_rsp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			combine_mode_q <= MODE_SUM;
		end else if (cfg_we) begin
			combine_mode_q <= combine_mode_t'(cfg_wdata);
		end
	end

	hpdc_front #(
		.MAX_HARMONICS(MAX_HARMONICS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.harmonic (harmonic),
		.mode     (combine_mode_q),
		.job      (push_job),
		.job_push (job_push),
		.fifo_full(fifo_full)
	);

	hpdc_job_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (job_push),
		.push_job(push_job),
		.pop     (job_pop),
		.pop_job (pop_job),
		.full    (fifo_full),
		.empty   (fifo_empty)
	);

	hpdc_log_db u_log (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (log_req),
		.rsp   (log_rsp)
	);

	hpdc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.job      (pop_job),
		.job_empty(fifo_empty),
		.job_pop  (job_pop),
		.log_req  (log_req),
		.log_rsp  (log_rsp),
		.result   (result)
	);

endmodule
